>>> rtl/core/stlg_pkg.sv
`timescale 1ns / 1ps

package stlg_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CONTROL = 2'd0;
	localparam logic [1:0] CFG_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_HEIGHT  = 2'd2;

	localparam logic [9:0]  WIDTH_RESET  = 10'd512;
	localparam logic [8:0]  HEIGHT_RESET = 9'd256;

	// Sprite size codes: the code is log2 of the side in tiles.
	localparam logic [1:0] SIZE_1X1 = 2'd0;
	localparam logic [1:0] SIZE_2X2 = 2'd1;
	localparam logic [1:0] SIZE_4X4 = 2'd2;

	localparam logic [12:0] BANK_SHIFT3 = 13'h1000;
	localparam logic [12:0] BANK_SHIFT4 = 13'h0800;
	localparam logic [10:0] WRAP_LINES  = 11'd256;

	typedef struct packed {
		logic       flip_screen;
		logic       bank_shift3;
		logic [9:0] screen_width;
		logic [8:0] screen_height;
	} cfg_t;

	// One classified sprite, ready for expansion into tiles.
	typedef struct packed {
		logic [12:0] code;
		logic [10:0] x;
		logic [10:0] y;
		logic        flip_x;
		logic        flip_y;
		logic [1:0]  size;
	} desc_t;

	// Highest tile index along one axis for a size code.
	function automatic logic [1:0] size_mask(input logic [1:0] size);
		logic [1:0] m;
		case (size)
			SIZE_2X2: m = 2'b01;
			SIZE_4X4: m = 2'b11;
			default:  m = 2'b00;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/core/sprite_tile_list_generator_core.sv
`timescale 1ns / 1ps

// Sprite tile list generator.
// Input stream (s_*): one transaction carries one four-byte sprite record.
// Output stream (m_*): one transaction per 8x8 tile placement; each tile comes
// out twice, a normal copy and then a wrap copy 256 lines higher (m_tuser set).
// m_tlast marks the final placement of a sprite. A sprite of side n tiles gives
// 2*n*n placements: 2, 8 or 32.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 control, 1 screen width, 2 screen height) in the same cycle; other
// indexes are ignored. Write only while no sprite is in flight.
// The first placement of a record reaches m_tvalid through the front register,
// the queue, the sequencer's descriptor register and the output register. The
// expansion sequencer puts out one placement per cycle while the receiver does
// not stall, so a record occupies it for its 2*n*n placements, and the next
// record loads as the last placement of the previous one leaves.
// A front register and a two-entry queue take records ahead of the sequencer.
// When the receiver stalls, the output register holds its transaction and the
// sequencer waits; the front keeps accepting until the queue and its own register are full.
// Reset clears all control state and loads control 0, width 512, height 256.
module sprite_tile_list_generator_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // y_byte, x_high_byte, attribute_byte, code_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tile_code, tile_x, tile_y, mirror_x, mirror_y
	output logic        m_tuser,   // wrap_copy
	output logic        m_tlast
);
	import stlg_pkg::*;

	logic [7:0] control_q;
	logic [9:0] width_q;
	logic [8:0] height_q;
	cfg_t       cfg;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	desc_t      push_desc, pop_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONTROL: control_q <= cfg_data[7:0];
				CFG_WIDTH:   width_q   <= cfg_data;
				CFG_HEIGHT:  height_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.flip_screen   = control_q[0];
		cfg.bank_shift3   = control_q[7];
		cfg.screen_width  = width_q;
		cfg.screen_height = height_q;
	end

	stlg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	stlg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	stlg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> rtl/core/stlg_front.sv
`timescale 1ns / 1ps

module stlg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  stlg_pkg::cfg_t      cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,
	output logic                push_valid,
	input  logic                push_ready,
	output stlg_pkg::desc_t     push_desc
);
	import stlg_pkg::*;

	logic [7:0]  y_byte, x_high_byte, attr, code_byte;
	logic [1:0]  size;
	logic [3:0]  low;
	logic [12:0] bank;
	logic [11:0] span;
	logic [11:0] x_raw, y_raw;
	logic [11:0] x_flip, y_flip;
	desc_t       desc;
	desc_t       desc_s1;
	logic        valid_s1;
	logic        accept;

	assign y_byte      = s_tdata[7:0];
	assign x_high_byte = s_tdata[15:8];
	assign attr        = s_tdata[23:16];
	assign code_byte   = s_tdata[31:24];

	always_comb begin
		if (attr[7] && attr[3]) begin
			size = SIZE_4X4;
			low  = 4'd0;
		end else if (attr[3]) begin
			size = SIZE_2X2;
			low  = {attr[5], 1'b0, attr[4], 1'b0};
		end else begin
			size = SIZE_1X1;
			low  = attr[7:4];
		end
	end

	assign bank = code_byte[7] ? (cfg.bank_shift3 ? BANK_SHIFT3 : BANK_SHIFT4) : 13'd0;

	// Extent of the sprite beyond its first tile, in pixels.
	assign span   = {7'd0, size_mask(size), 3'b000};
	assign x_raw  = {3'd0, x_high_byte, attr[0]};
	assign y_raw  = {4'd0, y_byte};
	assign x_flip = {2'd0, cfg.screen_width} - x_raw - span;
	assign y_flip = {3'd0, cfg.screen_height} - y_raw - span;

	always_comb begin
		desc.code   = {2'd0, code_byte[6:0], 4'd0} + bank + {9'd0, low};
		desc.size   = size;
		desc.x      = cfg.flip_screen ? x_flip[10:0] : x_raw[10:0];
		desc.y      = cfg.flip_screen ? y_flip[10:0] : y_raw[10:0];
		desc.flip_x = attr[1] ^ cfg.flip_screen;
		desc.flip_y = attr[2] ^ cfg.flip_screen;
	end

	assign s_tready = !valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

	assign push_valid = valid_s1;
	assign push_desc  = desc_s1;

endmodule

>>> rtl/core/stlg_queue.sv
`timescale 1ns / 1ps

module stlg_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  stlg_pkg::desc_t push_desc,
	output logic            pop_valid,
	input  logic            pop_ready,
	output stlg_pkg::desc_t pop_desc
);
	import stlg_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(DEPTH)) && !do_pop |=> count_q == CNT_W'(DEPTH))
		else $error("full queue lost an entry without a pop");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
`endif

endmodule

>>> rtl/core/stlg_back.sv
`timescale 1ns / 1ps

module stlg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  stlg_pkg::desc_t pop_desc,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);
	import stlg_pkg::*;

	desc_t       desc_q;
	logic        busy_q;
	logic [1:0]  row_q, col_q;
	logic        wrap_q;
	logic [12:0] code_q;
	logic [1:0]  mask;
	logic [1:0]  dx, dy;
	logic [10:0] px, py;
	logic        last_tile, emit_last, adv;

	logic        out_valid_q;
	logic [12:0] out_code_q;
	logic [10:0] out_x_q, out_y_q;
	logic        out_mx_q, out_my_q, out_wrap_q, out_last_q;

	assign mask      = size_mask(desc_q.size);
	assign dx        = desc_q.flip_x ? (mask ^ col_q) : col_q;
	assign dy        = desc_q.flip_y ? (mask ^ row_q) : row_q;
	assign px        = desc_q.x + {6'd0, dx, 3'b000};
	assign py        = desc_q.y + {6'd0, dy, 3'b000} - (wrap_q ? WRAP_LINES : 11'd0);
	assign last_tile = (row_q == mask) && (col_q == mask);
	assign emit_last = last_tile && wrap_q;
	assign adv       = busy_q && (!out_valid_q || m_tready);

	// The next sprite loads in the same cycle as the last placement of this one.
	assign pop_ready = !busy_q || (adv && emit_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (pop_ready) begin
				busy_q <= pop_valid;
				row_q  <= '0;
				col_q  <= '0;
				wrap_q <= 1'b0;
			end else if (adv) begin
				wrap_q <= !wrap_q;
				if (wrap_q) begin
					if (col_q == mask) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			desc_q <= pop_desc;
			code_q <= pop_desc.code;
		end else if (adv && wrap_q) begin
			// A 2x2 sprite skips two codes at the end of each row.
			if (desc_q.size == SIZE_2X2 && col_q == mask) begin
				code_q <= code_q + 13'd3;
			end else begin
				code_q <= code_q + 13'd1;
			end
		end
		if (adv) begin
			out_code_q <= code_q;
			out_x_q    <= px;
			out_y_q    <= py;
			out_mx_q   <= desc_q.flip_x;
			out_my_q   <= desc_q.flip_y;
			out_wrap_q <= wrap_q;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_my_q, out_mx_q, out_y_q, out_x_q, out_code_q};
	assign m_tuser  = out_wrap_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (row_q <= mask) && (col_q <= mask))
		else $error("tile counters beyond sprite size");
	a_last_is_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("final placement is not a wrap copy");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !wrap_q |=> out_valid_q && !out_wrap_q && busy_q && wrap_q)
		else $error("normal copy not followed by its wrap copy");
`endif

endmodule
